FILE: hw/rtl/aab_pkg.sv
package aab_pkg;

  // default machine word width
  localparam int WORD_BITS_DEF = 32;

  // bits of the multiplier consumed per step of the shared unit
  localparam int MUL_DIGIT = 16;

  // stream widths
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 4;
  localparam int OUT_TDATA_W = 88;

  // instruction codes
  typedef enum logic [3:0] {
    OP_LOAD  = 4'd0,
    OP_STORE = 4'd1,
    OP_ADD   = 4'd2,
    OP_SUB   = 4'd3,
    OP_MUL   = 4'd4,
    OP_DIV   = 4'd5,
    OP_MOD   = 4'd6,
    OP_POW   = 4'd7,
    OP_CLEAR = 4'd8,
    OP_BR    = 4'd9,
    OP_BRZ   = 4'd10,
    OP_BRNEG = 4'd11,
    OP_HALT  = 4'd12
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CANCEL   = 2'd1,
    ST_DIV_ZERO = 2'd2
  } status_t;

  // shared unit operation
  typedef enum logic {
    K_MUL = 1'b0,
    K_DIV = 1'b1
  } kind_t;

  typedef struct packed {
    logic  start;
    kind_t kind;
  } iu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iu_rsp_t;

endpackage

FILE: hw/rtl/aab_iter_unit.sv
// Shared iterative unit: digit-serial multiply (low word) or restoring
// unsigned divide, one digit or one quotient bit per cycle.
module aab_iter_unit #(
  parameter int WORD_BITS = aab_pkg::WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  aab_pkg::iu_req_t     req,
  input  logic [WORD_BITS-1:0] opa,      // mul: multiplicand, div: dividend
  input  logic [WORD_BITS-1:0] opb,      // mul: multiplier,   div: divisor
  output aab_pkg::iu_rsp_t     rsp,
  output logic [WORD_BITS-1:0] prod_rem, // mul: product, div: remainder
  output logic [WORD_BITS-1:0] quot      // div: quotient
);

  localparam int W  = WORD_BITS;
  localparam int DG = (W < aab_pkg::MUL_DIGIT) ? W : aab_pkg::MUL_DIGIT;
  localparam int ND = (W + DG - 1) / DG;
  localparam int CW = $clog2(W);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  aab_pkg::kind_t        kind_r, kind_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [W-1:0]          a_r, a_nxt;   // partial product / remainder
  logic [W-1:0]          b_r, b_nxt;   // multiplicand / divisor
  logic [W-1:0]          c_r, c_nxt;   // multiplier / dividend -> quotient
  logic [W-1:0]          pp;
  logic [W:0]            trial;
  logic                  ge;

  // one partial product per step, low word only
  assign pp = b_r * W'(c_r[DG-1:0]);

  // one restoring divide step
  assign trial = {a_r, c_r[W-1]} - {1'b0, b_r};
  assign ge    = ~trial[W];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    kind_nxt = kind_r;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    c_nxt    = c_r;
    if (req.start) begin
      kind_nxt = req.kind;
      busy_nxt = 1'b1;
      a_nxt    = '0;
      if (req.kind == aab_pkg::K_DIV) begin
        b_nxt   = opb;
        c_nxt   = opa;
        cnt_nxt = CW'(W - 1);
      end else begin
        b_nxt   = opa;
        c_nxt   = opb;
        cnt_nxt = CW'(ND - 1);
      end
    end else if (busy_r) begin
      if (kind_r == aab_pkg::K_MUL) begin
        a_nxt = a_r + pp;
        b_nxt = b_r << DG;
        c_nxt = c_r >> DG;
      end else begin
        a_nxt = ge ? trial[W-1:0] : {a_r[W-2:0], c_r[W-1]};
        c_nxt = {c_r[W-2:0], ge};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    kind_r <= kind_nxt;
    cnt_r  <= cnt_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    c_r    <= c_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign prod_rem = a_r;
  assign quot     = c_r;

endmodule

FILE: hw/rtl/accumulator_alu_branch_unit.sv
// Execute unit of an accumulator machine.
// Input stream: one instruction per request; in_tuser carries the opcode,
// in_tdata the fetched memory word. Output stream: one result per
// instruction with the new accumulator, flags, store, branch, halt and status.
// One instruction is worked on at a time; in_tready is high only while the
// block is idle. A multiply, divide, modulo or power runs on one shared
// iterative unit (mul = ceil(WORD_BITS/16) digit steps, div/mod = WORD_BITS
// quotient-bit steps). A divide or modulo by zero does not start the unit
// and ends with the zero-divisor status. A power does up to two unit
// multiplies per exponent bit and stops after the top set exponent bit.
// The next instruction is taken in the cycle after a result is placed in the
// output register. A finished result waits in an internal stage while
// out_tready is low; the next instruction is taken even if the output
// register is still full, and its result waits until the register frees.
// Reset clears the accumulator and both flags and empties the output.
module accumulator_alu_branch_unit #(
  parameter int WORD_BITS = aab_pkg::WORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [aab_pkg::IN_TDATA_W-1:0]  in_tdata,   // [31:0] operand_value
  input  logic [aab_pkg::IN_TUSER_W-1:0]  in_tuser,   // [3:0] opcode
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] accumulator, [32] zero_flag, [33] negative_flag,
  // [65:34] store_data, [66] store_enable, [67] branch_taken,
  // [83:68] branch_target, [84] halt_request, [86:85] status, [87] zero pad
  output logic [aab_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int W = WORD_BITS;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_DIV  = 7'b0000100,
    S_POW  = 7'b0001000,
    S_PMUL = 7'b0010000,
    S_PSQ  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [W-1:0]                   acc_r, acc_nxt;
  logic                           z_r, z_nxt;
  logic                           n_r, n_nxt;
  aab_pkg::op_t                   op_r, op_nxt;
  logic [15:0]                    tgt_r, tgt_nxt;
  logic                           dz_r, dz_nxt;
  logic                           dneg_r, dneg_nxt;
  logic [W-1:0]                   base_r, base_nxt;
  logic [W-1:0]                   exp_r, exp_nxt;
  logic [W-1:0]                   pw_r, pw_nxt;
  logic                           out_tvalid_r, out_tvalid_nxt;
  logic [aab_pkg::OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  aab_pkg::op_t                   in_op;
  logic [W-1:0]                   opnd_in;
  logic [W-1:0]                   acc_abs, opnd_abs;
  logic                           acc_wr;
  logic [W-1:0]                   acc_val;

  aab_pkg::iu_req_t               iu_req;
  aab_pkg::iu_rsp_t               iu_rsp;
  logic [W-1:0]                   iu_a, iu_b;
  logic [W-1:0]                   iu_prod_rem, iu_quot;

  // result fields
  logic [31:0]                    res_acc;
  logic                           res_taken, res_cancel, res_store;
  logic [31:0]                    res_sdata;
  logic [15:0]                    res_tgt;
  logic                           res_halt;
  aab_pkg::status_t               res_status;

  assign in_op    = aab_pkg::op_t'(in_tuser);
  assign opnd_in  = W'($signed(in_tdata));
  assign acc_abs  = acc_r[W-1] ? (-acc_r) : acc_r;
  assign opnd_abs = opnd_in[W-1] ? (-opnd_in) : opnd_in;

  assign in_tready = (state_r == S_IDLE);

  aab_iter_unit #(
    .WORD_BITS(WORD_BITS)
  ) u_iter (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (iu_req),
    .opa      (iu_a),
    .opb      (iu_b),
    .rsp      (iu_rsp),
    .prod_rem (iu_prod_rem),
    .quot     (iu_quot)
  );

  // result fields from the finished instruction
  always_comb begin
    res_acc    = 32'($signed(acc_r));
    res_store  = (op_r == aab_pkg::OP_STORE);
    res_sdata  = res_store ? res_acc : 32'd0;
    res_taken  = (op_r == aab_pkg::OP_BR) ||
                 ((op_r == aab_pkg::OP_BRZ) && z_r) ||
                 ((op_r == aab_pkg::OP_BRNEG) && n_r);
    res_cancel = ((op_r == aab_pkg::OP_BRZ) && !z_r) ||
                 ((op_r == aab_pkg::OP_BRNEG) && !n_r);
    res_tgt    = res_taken ? tgt_r : 16'd0;
    res_halt   = (op_r == aab_pkg::OP_HALT);
    if (dz_r) begin
      res_status = aab_pkg::ST_DIV_ZERO;
    end else if (res_cancel) begin
      res_status = aab_pkg::ST_CANCEL;
    end else begin
      res_status = aab_pkg::ST_OK;
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    acc_nxt        = acc_r;
    z_nxt          = z_r;
    n_nxt          = n_r;
    op_nxt         = op_r;
    tgt_nxt        = tgt_r;
    dz_nxt         = dz_r;
    dneg_nxt       = dneg_r;
    base_nxt       = base_r;
    exp_nxt        = exp_r;
    pw_nxt         = pw_r;
    out_tdata_nxt  = out_tdata_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    iu_req.start   = 1'b0;
    iu_req.kind    = aab_pkg::K_MUL;
    iu_a           = acc_r;
    iu_b           = opnd_in;
    acc_wr         = 1'b0;
    acc_val        = '0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_op;
          tgt_nxt   = in_tdata[15:0];
          dz_nxt    = 1'b0;
          state_nxt = S_DONE;
          case (in_op)
            aab_pkg::OP_LOAD: begin
              acc_wr  = 1'b1;
              acc_val = opnd_in;
            end
            aab_pkg::OP_ADD: begin
              acc_wr  = 1'b1;
              acc_val = acc_r + opnd_in;
            end
            aab_pkg::OP_SUB: begin
              acc_wr  = 1'b1;
              acc_val = acc_r - opnd_in;
            end
            aab_pkg::OP_MUL: begin
              iu_req.start = 1'b1;
              state_nxt    = S_MUL;
            end
            aab_pkg::OP_DIV: begin
              if (opnd_in == '0) begin
                dz_nxt = 1'b1;
              end else begin
                iu_req.start = 1'b1;
                iu_req.kind  = aab_pkg::K_DIV;
                iu_a         = acc_abs;
                iu_b         = opnd_abs;
                dneg_nxt     = acc_r[W-1] ^ opnd_in[W-1];
                state_nxt    = S_DIV;
              end
            end
            aab_pkg::OP_MOD: begin
              if (opnd_in == '0) begin
                dz_nxt = 1'b1;
              end else begin
                iu_req.start = 1'b1;
                iu_req.kind  = aab_pkg::K_DIV;
                state_nxt    = S_DIV;
              end
            end
            aab_pkg::OP_POW: begin
              pw_nxt    = W'(1);
              base_nxt  = acc_r;
              exp_nxt   = opnd_in;
              state_nxt = S_POW;
            end
            aab_pkg::OP_CLEAR: begin
              acc_wr  = 1'b1;
              acc_val = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_MUL: begin
        if (iu_rsp.done) begin
          acc_wr    = 1'b1;
          acc_val   = iu_prod_rem;
          state_nxt = S_DONE;
        end
      end

      S_DIV: begin
        if (iu_rsp.done) begin
          acc_wr = 1'b1;
          if (op_r == aab_pkg::OP_DIV) begin
            acc_val = dneg_r ? (-iu_quot) : iu_quot;
          end else begin
            acc_val = iu_prod_rem;
          end
          state_nxt = S_DONE;
        end
      end

      // square-and-multiply over the exponent bits, lowest first
      S_POW: begin
        if (exp_r == '0) begin
          acc_wr    = 1'b1;
          acc_val   = pw_r;
          state_nxt = S_DONE;
        end else if (exp_r[0]) begin
          iu_req.start = 1'b1;
          iu_a         = pw_r;
          iu_b         = base_r;
          state_nxt    = S_PMUL;
        end else begin
          iu_req.start = 1'b1;
          iu_a         = base_r;
          iu_b         = base_r;
          state_nxt    = S_PSQ;
        end
      end

      S_PMUL: begin
        if (iu_rsp.done) begin
          pw_nxt = iu_prod_rem;
          if (exp_r[W-1:1] == '0) begin
            exp_nxt   = '0;
            state_nxt = S_POW;
          end else begin
            iu_req.start = 1'b1;
            iu_a         = base_r;
            iu_b         = base_r;
            state_nxt    = S_PSQ;
          end
        end
      end

      S_PSQ: begin
        if (iu_rsp.done) begin
          base_nxt  = iu_prod_rem;
          exp_nxt   = exp_r >> 1;
          state_nxt = S_POW;
        end
      end

      // hand the result to the output register once it is free
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {1'b0, res_status, res_halt, res_tgt, res_taken,
                            res_store, res_sdata, n_r, z_r, res_acc};
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // accumulator write sets both flags
    if (acc_wr) begin
      acc_nxt = acc_val;
      z_nxt   = (acc_val == '0);
      n_nxt   = acc_val[W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      acc_r        <= '0;
      z_r          <= 1'b0;
      n_r          <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      acc_r        <= acc_nxt;
      z_r          <= z_nxt;
      n_r          <= n_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    op_r        <= op_nxt;
    tgt_r       <= tgt_nxt;
    dz_r        <= dz_nxt;
    dneg_r      <= dneg_nxt;
    base_r      <= base_nxt;
    exp_r       <= exp_nxt;
    pw_r        <= pw_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // flags always agree with the accumulator they were taken from
  ap_neg_flag: assert property (@(posedge clk) disable iff (!rst_n)
    n_r |-> acc_r[W-1])
    else $error("negative flag set with non-negative accumulator");

  ap_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    z_r |-> (acc_r == '0))
    else $error("zero flag set with nonzero accumulator");

  // shared unit is only started when free
  ap_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    iu_req.start |-> !iu_rsp.busy)
    else $error("shared unit started while busy");

  // unit results only arrive while the sequencer waits for them
  ap_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    iu_rsp.done |-> (state_r == S_MUL || state_r == S_DIV ||
                     state_r == S_PMUL || state_r == S_PSQ))
    else $error("shared unit finished outside a wait state");

  // no new instruction while the unit still iterates
  ap_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !iu_rsp.busy)
    else $error("ready while shared unit busy");

endmodule
